>>> src/cbb_pkg.sv
`default_nettype none

package cbb_pkg;

    localparam int unsigned COORD_BITS_DEF = 12;
    localparam int unsigned BOX_BITS       = 12;
    localparam int unsigned CHAN_BITS      = 8;
    localparam int unsigned SUM_BITS       = CHAN_BITS + 2;
    localparam int unsigned PROD_BITS      = 2 * SUM_BITS;
    localparam int unsigned RECIP_SHIFT    = 11;

    // 683 / 2048 gives an exact floor(n / 3) for every n up to 765
    localparam logic [SUM_BITS-1:0] RECIP_THIRD = SUM_BITS'(683);

    typedef struct packed {
        logic fire;
        logic changed;
        logic eol;
        logic eof;
    } t_step;

    typedef struct packed {
        logic                found;
        logic [BOX_BITS-1:0] left;
        logic [BOX_BITS-1:0] top;
        logic [BOX_BITS-1:0] right;
        logic [BOX_BITS-1:0] bottom;
    } t_box;

    function automatic logic [CHAN_BITS-1:0] gray_of(
        input logic [CHAN_BITS-1:0] r,
        input logic [CHAN_BITS-1:0] g,
        input logic [CHAN_BITS-1:0] b
    );
        logic [SUM_BITS-1:0]  sum;
        logic [PROD_BITS-1:0] prod;
        sum  = SUM_BITS'(r) + SUM_BITS'(g) + SUM_BITS'(b);
        prod = PROD_BITS'(sum) * PROD_BITS'(RECIP_THIRD);
        return prod[RECIP_SHIFT +: CHAN_BITS];
    endfunction

endpackage

`default_nettype wire

>>> src/cbb_diff.sv
`default_nettype none

module cbb_diff (
    input  wire logic [cbb_pkg::CHAN_BITS-1:0] i_in_red,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0] i_in_green,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0] i_in_blue,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0] i_ref_red,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0] i_ref_green,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0] i_ref_blue,
    output logic                               o_changed
);
    import cbb_pkg::*;

    logic [CHAN_BITS-1:0] gray_in;
    logic [CHAN_BITS-1:0] gray_ref;

    always_comb begin
        gray_in   = gray_of(i_in_red, i_in_green, i_in_blue);
        gray_ref  = gray_of(i_ref_red, i_ref_green, i_ref_blue);
        o_changed = (gray_in != gray_ref);
    end

endmodule

`default_nettype wire

>>> src/cbb_track.sv
`default_nettype none

module cbb_track #(
    parameter int unsigned COORD_BITS = cbb_pkg::COORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cbb_pkg::t_step i_step,
    output cbb_pkg::t_box      o_box
);
    import cbb_pkg::*;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
    localparam int unsigned EXT_BITS = COORD_BITS + BOX_BITS;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_min_x, n_min_x;
    logic [COORD_BITS-1:0] r_min_y, n_min_y;
    logic [COORD_BITS-1:0] r_max_x, n_max_x;
    logic [COORD_BITS-1:0] r_max_y, n_max_y;
    logic                  r_any, n_any;

    logic [COORD_BITS-1:0] u_min_x, u_min_y, u_max_x, u_max_y;
    logic                  u_any;
    logic [EXT_BITS-1:0]   ext_l, ext_t, ext_r, ext_b;

    always_comb begin
        u_any   = r_any;
        u_min_x = r_min_x;
        u_min_y = r_min_y;
        u_max_x = r_max_x;
        u_max_y = r_max_y;
        if (i_step.changed) begin
            u_any = 1'b1;
            if (!r_any) begin
                u_min_x = r_col;
                u_min_y = r_row;
                u_max_x = r_col;
                u_max_y = r_row;
            end else begin
                if (r_col < r_min_x) u_min_x = r_col;
                if (r_col > r_max_x) u_max_x = r_col;
                if (r_row > r_max_y) u_max_y = r_row;
            end
        end

        ext_l = {{BOX_BITS{1'b0}}, u_min_x};
        ext_t = {{BOX_BITS{1'b0}}, u_min_y};
        ext_r = {{BOX_BITS{1'b0}}, u_max_x};
        ext_b = {{BOX_BITS{1'b0}}, u_max_y};

        o_box.found  = u_any;
        o_box.left   = u_any ? ext_l[BOX_BITS-1:0] : '0;
        o_box.top    = u_any ? ext_t[BOX_BITS-1:0] : '0;
        o_box.right  = u_any ? ext_r[BOX_BITS-1:0] : '0;
        o_box.bottom = u_any ? ext_b[BOX_BITS-1:0] : '0;

        n_col   = r_col;
        n_row   = r_row;
        n_any   = r_any;
        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        if (i_step.fire) begin
            if (i_step.eof) begin
                n_col   = '0;
                n_row   = '0;
                n_any   = 1'b0;
                n_min_x = '0;
                n_min_y = '0;
                n_max_x = '0;
                n_max_y = '0;
            end else begin
                n_any   = u_any;
                n_min_x = u_min_x;
                n_min_y = u_min_y;
                n_max_x = u_max_x;
                n_max_y = u_max_y;
                if (i_step.eol) begin
                    n_col = '0;
                    if (r_row != COORD_MAX) n_row = r_row + COORD_BITS'(1);
                end else if (r_col != COORD_MAX) begin
                    n_col = r_col + COORD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_any   <= 1'b0;
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_any   <= n_any;
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
        end
    end

endmodule

`default_nettype wire

>>> src/change_bounding_box.sv
// The result is registered when the end-of-frame beat leaves the input register.
// Throughput: one pixel beat per cycle; a held result stalls the next end-of-frame beat and the input behind it.
// The input register and the output register set this throughput.
// Reset clears the counters, the box and both valid flags; the first frame starts at x = y = 0.
`default_nettype none

module change_bounding_box #(
    parameter int unsigned COORD_BITS = cbb_pkg::COORD_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0]      i_in_red,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0]      i_in_green,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0]      i_in_blue,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0]      i_ref_red,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0]      i_ref_green,
    input  wire logic [cbb_pkg::CHAN_BITS-1:0]      i_ref_blue,
    input  wire logic                               i_end_of_line,
    input  wire logic                               i_end_of_frame,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_found,
    output logic [cbb_pkg::BOX_BITS-1:0]            o_box_left,
    output logic [cbb_pkg::BOX_BITS-1:0]            o_box_top,
    output logic [cbb_pkg::BOX_BITS-1:0]            o_box_right,
    output logic [cbb_pkg::BOX_BITS-1:0]            o_box_bottom
);
    import cbb_pkg::*;

    logic                 r_s1_valid;
    logic [CHAN_BITS-1:0] r_in_red, r_in_green, r_in_blue;
    logic [CHAN_BITS-1:0] r_ref_red, r_ref_green, r_ref_blue;
    logic                 r_eol, r_eof;

    logic                 r_out_valid;
    t_box                 r_out;

    logic                 changed;
    logic                 s1_fire;
    t_step                step;
    t_box                 box;

    assign s1_fire = r_s1_valid && (!r_eof || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;

    cbb_diff u_diff (
        .i_in_red   (r_in_red),
        .i_in_green (r_in_green),
        .i_in_blue  (r_in_blue),
        .i_ref_red  (r_ref_red),
        .i_ref_green(r_ref_green),
        .i_ref_blue (r_ref_blue),
        .o_changed  (changed)
    );

    always_comb begin
        step.fire    = s1_fire;
        step.changed = changed;
        step.eol     = r_eol;
        step.eof     = r_eof;
    end

    cbb_track #(
        .COORD_BITS(COORD_BITS)
    ) u_track (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .o_box  (box)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_in_red    <= i_in_red;
            r_in_green  <= i_in_green;
            r_in_blue   <= i_in_blue;
            r_ref_red   <= i_ref_red;
            r_ref_green <= i_ref_green;
            r_ref_blue  <= i_ref_blue;
            r_eol       <= i_end_of_line;
            r_eof       <= i_end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && r_eof) begin
            r_out <= box;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out.found;
    assign o_box_left   = r_out.left;
    assign o_box_top    = r_out.top;
    assign o_box_right  = r_out.right;
    assign o_box_bottom = r_out.bottom;

    a_empty_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_box_left == '0 && o_box_top == '0
            && o_box_right == '0 && o_box_bottom == '0)
        else $error("empty frame reports a non-zero box");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found && COORD_BITS <= BOX_BITS |->
            o_box_left <= o_box_right && o_box_top <= o_box_bottom)
        else $error("box corners out of order");

    a_stall_holds_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_eof))
        else $error("stalled pixel beat lost");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> tb/change_bounding_box_tb.sv
`timescale 1ns / 100ps

module change_bounding_box_tb;

    localparam int unsigned CB        = cbb_pkg::COORD_BITS_DEF;
    localparam int unsigned BB        = cbb_pkg::BOX_BITS;
    localparam int unsigned CW        = cbb_pkg::CHAN_BITS;
    localparam logic [CB-1:0] COORD_TOP = {CB{1'b1}};
    localparam int          LIMIT     = 500000;
    localparam int          HOLD_CYCLES = 400;

    typedef struct packed {
        logic [CW-1:0] in_r;
        logic [CW-1:0] in_g;
        logic [CW-1:0] in_b;
        logic [CW-1:0] rf_r;
        logic [CW-1:0] rf_g;
        logic [CW-1:0] rf_b;
        logic          eol;
        logic          eof;
    } t_pixel;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [CW-1:0] i_in_red = '0;
    logic [CW-1:0] i_in_green = '0;
    logic [CW-1:0] i_in_blue = '0;
    logic [CW-1:0] i_ref_red = '0;
    logic [CW-1:0] i_ref_green = '0;
    logic [CW-1:0] i_ref_blue = '0;
    logic          i_end_of_line = 1'b0;
    logic          i_end_of_frame = 1'b0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic          o_found;
    logic [BB-1:0] o_box_left;
    logic [BB-1:0] o_box_top;
    logic [BB-1:0] o_box_right;
    logic [BB-1:0] o_box_bottom;

    t_pixel           pixel_q[$];
    cbb_pkg::t_box    expected_boxes[$];

    logic [CB-1:0] col_pos = '0;
    logic [CB-1:0] row_pos = '0;
    logic [CB-1:0] left_x = '0;
    logic [CB-1:0] top_y = '0;
    logic [CB-1:0] right_x = '0;
    logic [CB-1:0] bottom_y = '0;
    logic          seen_change = 1'b0;

    logic  in_fire = 1'b0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    hold_left = 0;
    int    hold_asked = 0;
    int    hold_done = 0;
    int    rx_cycle = 0;
    int    cycle_count = 0;
    int    error_count = 0;
    int    queued_items = 0;
    int    queued_frames = 0;

    change_bounding_box dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .i_ref_red      (i_ref_red),
        .i_ref_green    (i_ref_green),
        .i_ref_blue     (i_ref_blue),
        .i_end_of_line  (i_end_of_line),
        .i_end_of_frame (i_end_of_frame),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_box_left     (o_box_left),
        .o_box_top      (o_box_top),
        .o_box_right    (o_box_right),
        .o_box_bottom   (o_box_bottom)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned luma3(input logic [CW-1:0] r, input logic [CW-1:0] g,
                                          input logic [CW-1:0] b);
        return (int'(r) + int'(g) + int'(b)) / 3;
    endfunction

    function automatic t_pixel raw_pixel(input int ir, input int ig, input int ib, input int rr,
                                         input int rg, input int rb, input bit eol,
                                         input bit eof);
        t_pixel px;
        px.in_r = CW'(ir);
        px.in_g = CW'(ig);
        px.in_b = CW'(ib);
        px.rf_r = CW'(rr);
        px.rf_g = CW'(rg);
        px.rf_b = CW'(rb);
        px.eol  = eol;
        px.eof  = eof;
        return px;
    endfunction

    function automatic t_pixel make_pixel(input bit change, input bit eol, input bit eof);
        t_pixel px;
        px = raw_pixel($urandom, $urandom, $urandom, 0, 0, 0, eol, eof);
        if (change) begin
            do begin
                px.rf_r = CW'($urandom);
                px.rf_g = CW'($urandom);
                px.rf_b = CW'($urandom);
            end while (luma3(px.in_r, px.in_g, px.in_b) == luma3(px.rf_r, px.rf_g, px.rf_b));
        end else begin
            // same channel sum, so the same grey
            case ($urandom_range(0, 2))
                0: begin
                    px.rf_r = px.in_r;
                    px.rf_g = px.in_g;
                    px.rf_b = px.in_b;
                end
                1: begin
                    px.rf_r = px.in_g;
                    px.rf_g = px.in_b;
                    px.rf_b = px.in_r;
                end
                default: begin
                    px.rf_r = px.in_b;
                    px.rf_g = px.in_r;
                    px.rf_b = px.in_g;
                end
            endcase
        end
        return px;
    endfunction

    task automatic push_pixel(input t_pixel px);
        pixel_q = {pixel_q, px};
        queued_items++;
        if (px.eof) queued_frames++;
    endtask

    task automatic add_frame(input int width, input int height, input int permille,
                             input bit last_eol, input bit force_last);
        bit last;
        for (int y = 0; y < height; y++) begin
            for (int x = 0; x < width; x++) begin
                last = (y == height - 1) && (x == width - 1);
                push_pixel(make_pixel((force_last && last) || $urandom_range(0, 999) < permille,
                                      (x == width - 1) && (!last || last_eol), last));
            end
        end
    endtask

    task automatic add_ragged();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
            push_pixel(make_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                                  i == n - 1));
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            push_pixel(make_pixel($urandom_range(0, 1), $urandom_range(0, 2) == 0,
                                  $urandom_range(0, 5) == 0));
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_valid || expected_boxes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input cbb_pkg::t_box want,
                                   input cbb_pkg::t_box got);
        error_count++;
        if (error_count <= 10)
            $display({"mismatch, %s: expected found=%0b box=(%0d,%0d,%0d,%0d)",
                      " got found=%0b box=(%0d,%0d,%0d,%0d)"},
                     what, want.found, want.left, want.top, want.right, want.bottom,
                     got.found, got.left, got.top, got.right, got.bottom);
    endtask

    task automatic track_pixel(input t_pixel px);
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        cbb_pkg::t_box res;
        x = col_pos;
        y = row_pos;
        if (luma3(px.in_r, px.in_g, px.in_b) != luma3(px.rf_r, px.rf_g, px.rf_b)) begin
            if (!seen_change) begin
                left_x      = x;
                top_y       = y;
                right_x     = x;
                bottom_y    = y;
                seen_change = 1'b1;
            end else begin
                if (x < left_x) left_x = x;
                if (x > right_x) right_x = x;
                if (y > bottom_y) bottom_y = y;
            end
        end
        if (px.eof) begin
            res.found  = seen_change;
            res.left   = seen_change ? BB'(left_x) : '0;
            res.top    = seen_change ? BB'(top_y) : '0;
            res.right  = seen_change ? BB'(right_x) : '0;
            res.bottom = seen_change ? BB'(bottom_y) : '0;
            expected_boxes = {expected_boxes, res};
            col_pos     = '0;
            row_pos     = '0;
            left_x      = '0;
            top_y       = '0;
            right_x     = '0;
            bottom_y    = '0;
            seen_change = 1'b0;
        end else if (px.eol) begin
            col_pos = '0;
            if (row_pos != COORD_TOP) row_pos = row_pos + 1'b1;
        end else if (col_pos != COORD_TOP) begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // sender: bursts and gaps, hold the beat until taken
    always @(negedge i_clk) begin
        t_pixel px;
        logic   next_valid;
        if (i_rst_n && (!i_valid || in_fire)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pixel_q.size() > 0) begin
                px = pixel_q.pop_front();
                next_valid = 1'b1;
                i_in_red       <= px.in_r;
                i_in_green     <= px.in_g;
                i_in_blue      <= px.in_b;
                i_ref_red      <= px.rf_r;
                i_ref_green    <= px.rf_g;
                i_ref_blue     <= px.rf_b;
                i_end_of_line  <= px.eol;
                i_end_of_frame <= px.eof;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            i_valid <= next_valid;
        end
    end

    // receiver: rotating stall patterns plus an occasional long hold-off
    always @(negedge i_clk) begin
        logic rdy;
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (hold_asked != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end else begin
            case ((rx_cycle >> 7) % 4)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = (rx_cycle % 4) != 0;
                default: rdy = $urandom_range(0, 7) != 0;
            endcase
        end
        i_ready <= rdy;
    end

    always @(posedge i_clk) begin
        cbb_pkg::t_box got;
        cbb_pkg::t_box want;
        cycle_count++;
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.found  = o_found;
                got.left   = o_box_left;
                got.top    = o_box_top;
                got.right  = o_box_right;
                got.bottom = o_box_bottom;
                if (expected_boxes.size() == 0) begin
                    report_mismatch("unexpected beat", '0, got);
                end else begin
                    want = expected_boxes.pop_front();
                    if (got.found !== want.found || got.left !== want.left ||
                        got.top !== want.top || got.right !== want.right ||
                        got.bottom !== want.bottom)
                        report_mismatch("box", want, got);
                end
            end
            if (i_valid && o_ready)
                track_pixel(raw_pixel(i_in_red, i_in_green, i_in_blue, i_ref_red, i_ref_green,
                                      i_ref_blue, i_end_of_line, i_end_of_frame));
        end
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int rates[4];
        int start_items;
        int start_frames;
        int pick;
        rates = '{0, 40, 250, 1000};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single pixel at the origin, channel extremes
        push_pixel(raw_pixel(255, 255, 255, 0, 0, 0, 1, 1));
        // no change: identical and permuted channels
        push_pixel(raw_pixel(255, 255, 255, 255, 255, 255, 0, 0));
        push_pixel(raw_pixel(0, 0, 0, 0, 0, 0, 1, 0));
        push_pixel(raw_pixel(10, 20, 30, 30, 10, 20, 0, 0));
        push_pixel(raw_pixel(200, 100, 0, 0, 200, 100, 1, 1));
        // truncated division
        push_pixel(raw_pixel(1, 0, 0, 2, 0, 0, 0, 0));
        push_pixel(raw_pixel(2, 0, 0, 3, 0, 0, 0, 0));
        push_pixel(raw_pixel(255, 255, 254, 255, 255, 255, 1, 1));
        // frame ends mid-line, then the next frame starts at the origin
        push_pixel(raw_pixel(0, 0, 0, 0, 0, 0, 0, 0));
        push_pixel(raw_pixel(0, 0, 0, 0, 0, 0, 0, 0));
        push_pixel(raw_pixel(9, 9, 9, 0, 0, 0, 0, 1));
        push_pixel(raw_pixel(0, 0, 0, 3, 3, 3, 0, 1));
        // box grows left, right and down
        push_pixel(make_pixel(0, 0, 0));
        push_pixel(make_pixel(0, 0, 0));
        push_pixel(make_pixel(0, 0, 0));
        push_pixel(make_pixel(1, 1, 0));
        push_pixel(make_pixel(0, 0, 0));
        push_pixel(make_pixel(1, 0, 0));
        push_pixel(make_pixel(0, 0, 0));
        push_pixel(make_pixel(0, 0, 0));
        push_pixel(make_pixel(1, 1, 0));
        push_pixel(make_pixel(0, 1, 1));
        wait_drained();

        // fill the block behind a stalled output
        hold_asked++;
        for (int i = 0; i < 40; i++)
            add_frame($urandom_range(1, 2), 1, 500, 1, 0);
        wait_drained();

        start_items  = queued_items;
        start_frames = queued_frames;
        while (queued_items - start_items < 560 || queued_frames - start_frames < 45) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                add_frame($urandom_range(1, 40), $urandom_range(1, 3), rates[$urandom_range(0, 3)],
                          $urandom_range(0, 6) != 0, $urandom_range(0, 3) == 0);
            else if (pick < 70)
                add_frame($urandom_range(1, 8), $urandom_range(1, 5), rates[$urandom_range(0, 3)],
                          $urandom_range(0, 6) != 0, $urandom_range(0, 3) == 0);
            else if (pick < 85)
                add_ragged();
            else
                add_noise();
            if (pick == 50) begin
                hold_asked++;
                wait_drained();
            end
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (expected_boxes.size() > 0) begin
            report_mismatch("no beat arrived", expected_boxes[0], '0);
            error_count += expected_boxes.size() - 1;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
